/* hw/rtl/accel_fall_and_activity_detector_core_macros.svh */
// Assertion macros for the fall and activity detector.
// Each macro assumes clk and rst are visible in the using scope.
`ifndef ACCEL_FALL_AND_ACTIVITY_DETECTOR_CORE_MACROS_SVH
`define ACCEL_FALL_AND_ACTIVITY_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define AFAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afad same-cycle check failed");

// Next-cycle implication.
`define AFAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afad next-cycle check failed");

`endif

/* hw/rtl/afad_pkg.sv */
// Shared types and constants for the fall and activity detector.
// No dependencies.
`default_nettype none

package afad_pkg;

  localparam int WINDOW_SAMPLES     = 25;
  localparam int WINDOWS_PER_PERIOD = 60;

  localparam int AXIS_W   = 13;
  localparam int MAG_W    = 14;
  localparam int TIME_W   = 48;
  localparam int POINT_W  = 12;
  localparam int STEP_W   = 8;
  localparam int FALL_W   = 14;
  localparam int SPRD_W   = 13;
  localparam int CFG_W    = 14;
  localparam int CFG_IDX_W = 2;

  localparam int SAMPLE_IDX_W = $clog2(WINDOW_SAMPLES);
  localparam int WINDOW_IDX_W = (WINDOWS_PER_PERIOD > 1) ? $clog2(WINDOWS_PER_PERIOD) : 1;

  localparam logic [SAMPLE_IDX_W-1:0] LAST_SAMPLE = SAMPLE_IDX_W'(WINDOW_SAMPLES - 1);
  localparam logic [WINDOW_IDX_W-1:0] LAST_WINDOW = WINDOW_IDX_W'(WINDOWS_PER_PERIOD - 1);

  localparam logic [MAG_W-1:0]   IMMOBILE_LIMIT = MAG_W'(328);

  localparam logic [FALL_W-1:0]  FALL_THR_RESET   = FALL_W'(5000);
  localparam logic [SPRD_W-1:0]  SPRD_THR_RESET   = SPRD_W'(450);
  localparam logic [POINT_W-1:0] POINT_THR_RESET  = POINT_W'(1200);
  localparam logic [STEP_W-1:0]  POINT_STEP_RESET = STEP_W'(20);
  localparam logic [POINT_W-1:0] SLEEP_RESET      = POINT_W'(1200);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALL_THR   = 2'd0,
    REG_SPRD_THR   = 2'd1,
    REG_POINT_THR  = 2'd2,
    REG_POINT_STEP = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [FALL_W-1:0]  fall_thr;
    logic [SPRD_W-1:0]  spread_thr;
    logic [POINT_W-1:0] point_thr;
    logic [STEP_W-1:0]  point_step;
  } cfg_t;

  typedef struct packed {
    logic              last;
    logic              period_end;
    logic [MAG_W-1:0]  spread;
  } win_info_t;

  typedef struct packed {
    logic               fall;
    logic               changed;
    logic               awake;
    logic [POINT_W-1:0] sleep_pts;
    logic [POINT_W-1:0] wake_pts;
  } act_result_t;

endpackage

`default_nettype wire

/* hw/rtl/accel_fall_and_activity_detector_core.sv */
// Top level of the accelerometer fall and activity detector.
// Depends on afad_pkg, afad_mag, afad_window, afad_activity and the macros header.
`default_nettype none
`include "accel_fall_and_activity_detector_core_macros.svh"

// Takes one accelerometer sample per clock and returns one result per
// window of WINDOW_SAMPLES samples. A sample's magnitude is registered at
// acceptance; from that register the window, fall and point updates run in
// a single stage and load the result register, so a result becomes valid
// when the last sample of its window leaves that stage. Sustained rate is
// one sample per cycle, set by that single update stage; the input stalls
// only while a window-ending sample waits for a full result register to
// drain.
// Configuration takes effect on the next sample and should be written
// while no sample is in flight.
module accel_fall_and_activity_detector_core import afad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [AXIS_W-1:0] accel_x,
  input  logic signed [AXIS_W-1:0] accel_y,
  input  logic signed [AXIS_W-1:0] accel_z,
  input  logic [TIME_W-1:0]        sample_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MAG_W-1:0]         spread,
  output logic                     fall_detected,
  output logic                     state_changed,
  output logic                     now_awake,
  output logic [TIME_W-1:0]        period_start,
  output logic [POINT_W-1:0]       asleep_points,
  output logic [POINT_W-1:0]       awake_points
);

  cfg_t              cfg;
  logic [MAG_W-1:0]  in_mag;
  logic              s1_valid;
  logic [MAG_W-1:0]  s1_mag;
  logic [TIME_W-1:0] s1_time;
  logic              s1_go;
  win_info_t         win;
  logic [TIME_W-1:0] period_time;
  act_result_t       act;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fall_thr   <= FALL_THR_RESET;
      cfg.spread_thr <= SPRD_THR_RESET;
      cfg.point_thr  <= POINT_THR_RESET;
      cfg.point_step <= POINT_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FALL_THR:   cfg.fall_thr   <= cfg_data[FALL_W-1:0];
        REG_SPRD_THR:   cfg.spread_thr <= cfg_data[SPRD_W-1:0];
        REG_POINT_THR:  cfg.point_thr  <= cfg_data[POINT_W-1:0];
        REG_POINT_STEP: cfg.point_step <= cfg_data[STEP_W-1:0];
      endcase
    end
  end

  afad_mag u_mag (
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .mag     (in_mag)
  );

  assign s1_go    = s1_valid && (!win.last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mag  <= in_mag;
      s1_time <= sample_time;
    end
  end

  afad_window u_window (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_go),
    .mag         (s1_mag),
    .sample_time (s1_time),
    .info        (win),
    .period_time (period_time)
  );

  afad_activity u_activity (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_go && win.last),
    .spread     (win.spread),
    .period_end (win.period_end),
    .cfg        (cfg),
    .res        (act)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && win.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && win.last) begin
      spread        <= win.spread;
      fall_detected <= act.fall;
      state_changed <= act.changed;
      now_awake     <= act.awake;
      period_start  <= period_time;
      asleep_points <= act.sleep_pts;
      awake_points  <= act.wake_pts;
    end
  end

  `AFAD_ASSERT_NOW(a_points_conserved, out_valid,
    ({1'b0, asleep_points} + {1'b0, awake_points}) == {1'b0, SLEEP_RESET})
  `AFAD_ASSERT_NOW(a_change_matches_state, out_valid && state_changed,
    now_awake == (asleep_points <= awake_points))
  `AFAD_ASSERT_NOW(a_period_end_is_last, s1_valid && win.period_end, win.last)
  `AFAD_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_go, s1_valid && $stable(s1_mag))

endmodule

`default_nettype wire

/* hw/rtl/afad_mag.sv */
// L1 magnitude of one three-axis sample.
// Depends on afad_pkg.
`default_nettype none

module afad_mag import afad_pkg::*; (
  input  logic signed [AXIS_W-1:0] accel_x,
  input  logic signed [AXIS_W-1:0] accel_y,
  input  logic signed [AXIS_W-1:0] accel_z,
  output logic        [MAG_W-1:0]  mag
);

  function automatic logic [MAG_W-1:0] abs_axis(input logic signed [AXIS_W-1:0] v);
    logic signed [MAG_W-1:0] w;
    w = {{(MAG_W-AXIS_W){v[AXIS_W-1]}}, v};
    return v[AXIS_W-1] ? MAG_W'(-w) : MAG_W'(w);
  endfunction

  assign mag = abs_axis(accel_x) + abs_axis(accel_y) + abs_axis(accel_z);

endmodule

`default_nettype wire

/* hw/rtl/afad_window.sv */
// Window min/max tracking, sample and window counters, period timestamp.
// Depends on afad_pkg.
`default_nettype none

module afad_window import afad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [MAG_W-1:0]  mag,
  input  logic [TIME_W-1:0] sample_time,
  output win_info_t         info,
  output logic [TIME_W-1:0] period_time
);

  logic [SAMPLE_IDX_W-1:0] sample_index;
  logic [WINDOW_IDX_W-1:0] window_index;
  logic [MAG_W-1:0]        window_max;
  logic [MAG_W-1:0]        window_min;
  logic [MAG_W-1:0]        window_max_next;
  logic [MAG_W-1:0]        window_min_next;
  logic                    first;

  assign first = (sample_index == '0);

  always_comb begin
    if (first) begin
      window_max_next = mag;
      window_min_next = mag;
    end else begin
      window_max_next = (mag >= window_max) ? mag : window_max;
      window_min_next = (mag < window_min) ? mag : window_min;
    end
  end

  assign info.last       = (sample_index == LAST_SAMPLE);
  assign info.period_end = info.last && (window_index == LAST_WINDOW);
  assign info.spread     = window_max_next - window_min_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      window_index <= '0;
      window_max   <= '0;
      window_min   <= '1;
      period_time  <= '0;
    end else if (advance) begin
      window_max <= window_max_next;
      window_min <= window_min_next;
      if (first && window_index == '0) begin
        period_time <= sample_time;
      end
      if (info.last) begin
        sample_index <= '0;
        window_index <= info.period_end ? '0 : window_index + 1'b1;
      end else begin
        sample_index <= sample_index + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/afad_activity.sv */
// Fall stages, asleep/awake point counters and activity state.
// Depends on afad_pkg.
`default_nettype none

module afad_activity import afad_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [MAG_W-1:0] spread,
  input  logic             period_end,
  input  cfg_t             cfg,
  output act_result_t      res
);

  logic [POINT_W-1:0] sleep_points;
  logic [POINT_W-1:0] wake_points;
  logic               was_awake;
  logic               peak_seen;
  logic               fall_possible;
  logic               fall_likely;

  logic [POINT_W-1:0] sleep_points_next;
  logic [POINT_W-1:0] wake_points_next;
  logic [POINT_W:0]   sleep_inc;
  logic [POINT_W:0]   wake_add;
  logic               immobile;
  logic               fall_likely_next;
  logic               fall_possible_next;
  logic               peak_seen_next;
  logic               awake_now;

  assign immobile  = (spread <= IMMOBILE_LIMIT);
  assign sleep_inc = {1'b0, sleep_points} + 1'b1;
  assign wake_add  = {1'b0, wake_points} + {{(POINT_W+1-STEP_W){1'b0}}, cfg.point_step};

  always_comb begin
    sleep_points_next = sleep_points;
    wake_points_next  = wake_points;
    if (immobile) begin
      if (sleep_inc < {1'b0, cfg.point_thr} && wake_points > POINT_W'(1)) begin
        sleep_points_next = sleep_points + 1'b1;
        wake_points_next  = wake_points - 1'b1;
      end
    end else begin
      if (wake_add < {1'b0, cfg.point_thr} &&
          sleep_points > {{(POINT_W-STEP_W){1'b0}}, cfg.point_step}) begin
        sleep_points_next = sleep_points - {{(POINT_W-STEP_W){1'b0}}, cfg.point_step};
        wake_points_next  = POINT_W'(wake_add);
      end
    end
  end

  assign res.sleep_pts = sleep_points_next;
  assign res.wake_pts  = wake_points_next;

  assign res.fall         = fall_likely && (spread <= {1'b0, cfg.spread_thr});
  assign fall_likely_next = fall_possible && (spread <= {cfg.spread_thr, 1'b0});
  assign fall_possible_next = peak_seen && (spread < cfg.fall_thr);
  assign peak_seen_next   = (spread >= cfg.fall_thr);

  assign awake_now   = !(sleep_points_next > wake_points_next);
  assign res.changed = period_end && (awake_now != was_awake);
  assign res.awake   = period_end ? awake_now : was_awake;

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_points  <= SLEEP_RESET;
      wake_points   <= '0;
      was_awake     <= 1'b0;
      peak_seen     <= 1'b0;
      fall_possible <= 1'b0;
      fall_likely   <= 1'b0;
    end else if (advance) begin
      sleep_points  <= sleep_points_next;
      wake_points   <= wake_points_next;
      was_awake     <= res.awake;
      peak_seen     <= peak_seen_next;
      fall_possible <= fall_possible_next;
      fall_likely   <= fall_likely_next;
    end
  end

endmodule

`default_nettype wire
